FILE: rtl/sm3_pkg.sv
// SM3 package: initial value, round constants and round helper functions.
// Used by sm3_core and sm3_hash; no dependencies.
`default_nettype none
package sm3_pkg;

  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;

  typedef logic [7:0][31:0] word8_t;

  localparam word8_t IV = {32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
                           32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f};

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sm3_core.sv
// SM3 compression core: 64 rounds, one per cycle, on the block held in a memory.
// Depends on sm3_pkg. Message schedule window is a 16-entry memory.
`default_nettype none
module sm3_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [3:0]          ld_addr,
  input  wire logic [31:0]         ld_data,
  input  wire logic                ld_en,
  input  wire sm3_pkg::word8_t     cv_in,
  output logic                     busy,
  output logic                     done,
  output sm3_pkg::word8_t          cv_out
);

  // Schedule window memory: written by loader or expansion, read at six taps
  logic [31:0] win_r [16];
  logic [6:0]  j_r, j_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  sm3_pkg::word8_t wr_r, wr_nxt;
  logic [3:0]  t4;
  logic [31:0] w_new, wj, wj4, a12, ss1, ss2, ff, gg, tt1, tt2, tj;

  assign t4 = j_r[3:0] + 4'd4;

  always_comb begin
    w_new = sm3_pkg::perm1(win_r[t4] ^ win_r[t4 + 4'd7] ^
                           sm3_pkg::rotl(win_r[t4 + 4'd13], 5'd15))
            ^ sm3_pkg::rotl(win_r[t4 + 4'd3], 5'd7) ^ win_r[t4 + 4'd10];
    wj  = win_r[j_r[3:0]];
    wj4 = (j_r >= 7'd12) ? w_new : win_r[t4];
    tj  = (j_r < 7'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
    a12 = sm3_pkg::rotl(wr_r[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + wr_r[4] + sm3_pkg::rotl(tj, j_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j_r < 7'd16) begin
      ff = wr_r[0] ^ wr_r[1] ^ wr_r[2];
      gg = wr_r[4] ^ wr_r[5] ^ wr_r[6];
    end else begin
      ff = (wr_r[0] & wr_r[1]) | (wr_r[0] & wr_r[2]) | (wr_r[1] & wr_r[2]);
      gg = (wr_r[4] & wr_r[5]) | (~wr_r[4] & wr_r[6]);
    end
    tt1 = ff + wr_r[3] + ss2 + (wj ^ wj4);
    tt2 = gg + wr_r[7] + ss1 + wj;
  end

  // Round sequencing
  always_comb begin
    run_nxt  = run_r;
    j_nxt    = j_r;
    wr_nxt   = wr_r;
    done_nxt = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
      j_nxt   = '0;
      wr_nxt  = cv_in;
    end else if (run_r) begin
      wr_nxt = {wr_r[6], sm3_pkg::rotl(wr_r[5], 5'd19), wr_r[4], sm3_pkg::perm0(tt2),
                wr_r[2], sm3_pkg::rotl(wr_r[1], 5'd9), wr_r[0], tt1};
      j_nxt  = j_r + 7'd1;
      if (j_r == 7'd63) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      j_r    <= '0;
      done_r <= 1'b0;
      wr_r   <= '0;
    end else begin
      run_r  <= run_nxt;
      j_r    <= j_nxt;
      done_r <= done_nxt;
      wr_r   <= wr_nxt;
    end
  end

  // Window memory writes
  always_ff @(posedge clk) begin
    if (ld_en) begin
      win_r[ld_addr] <= ld_data;
    end else if (run_r && j_r >= 7'd12) begin
      win_r[t4] <= w_new;
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign cv_out = cv_in ^ wr_r;

endmodule
`default_nettype wire

FILE: rtl/sm3_hash.sv
// SM3 hash engine, 256-bit digest. Input: one message word a beat, taken only
// while idle; a non-last word keeps it idle unless it completes a block. That
// word starts a compression: 64 rounds, one a cycle in sm3_core, then the
// result is folded into the chaining value, and no input is taken meanwhile.
// A last word adds padding words at one a cycle, one or two compressions and
// eight output beats. Throughput is set by the single round unit. Depends on
// sm3_pkg.
`default_nettype none
module sm3_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_message_word,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_digest_done
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_COMP = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t          st_r, st_nxt;
  sm3_pkg::word8_t cv_r, cv_nxt, cv_new;
  logic [63:0]     bits_r, bits_nxt;
  logic [3:0]      fill_r, fill_nxt;
  logic            fin_r, fin_nxt;   // padding in progress
  logic            xtra_r, xtra_nxt; // 0x80 word still owed
  logic            lhi_r, lhi_nxt;   // length high word placed in this block
  logic            pad_done_r, pad_done_nxt;
  logic [2:0]      oi_r, oi_nxt;
  logic            ld_en, start, core_busy, core_done;
  logic [31:0]     ld_data, pad_w, keep;
  logic [2:0]      nb;
  logic            acc;

  sm3_core u_core (
    .clk, .rst_n, .start, .ld_addr(fill_r), .ld_data, .ld_en,
    .cv_in(cv_r), .busy(core_busy), .done(core_done), .cv_out(cv_new)
  );

  assign in_ready = (st_r == S_IDLE);
  assign acc = in_valid && in_ready;
  assign nb  = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;

  always_comb begin
    keep  = (nb == 3'd0) ? 32'h0 : (32'hffffffff << {(3'd4 - nb), 3'b000});
    pad_w = (in_message_word & keep) | (32'h80 << {(2'd3 - nb[1:0]), 3'b000});
  end

  // Control: load words, schedule padding, compress, emit digest
  always_comb begin
    st_nxt   = st_r;
    cv_nxt   = cv_r;
    bits_nxt = bits_r;
    fill_nxt = fill_r;
    fin_nxt  = fin_r;
    xtra_nxt = xtra_r;
    lhi_nxt  = lhi_r;
    oi_nxt   = oi_r;
    ld_en    = 1'b0;
    ld_data  = in_message_word;
    start    = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          ld_en    = 1'b1;
          fill_nxt = fill_r + 4'd1;
          if (!in_is_last) begin
            bits_nxt = bits_r + 64'd32;
          end else begin
            bits_nxt = bits_r + {58'd0, nb, 3'b000};
            fin_nxt  = 1'b1;
            xtra_nxt = (nb == 3'd4);
            if (nb != 3'd4) ld_data = pad_w;
          end
          if (fill_r == 4'd15) begin
            start  = 1'b1;
            st_nxt = S_COMP;
          end else if (in_is_last) begin
            st_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        ld_en    = 1'b1;
        fill_nxt = fill_r + 4'd1;
        if (xtra_r) begin
          ld_data  = 32'h80000000;
          xtra_nxt = 1'b0;
        end else if (fill_r == 4'd14) begin
          ld_data = bits_r[63:32];
          lhi_nxt = 1'b1;
        end else if (fill_r == 4'd15 && lhi_r) begin
          ld_data = bits_r[31:0];
          fin_nxt = 1'b0;
          lhi_nxt = 1'b0;
        end else begin
          ld_data = 32'h0;
        end
        if (fill_r == 4'd15) begin
          start  = 1'b1;
          st_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (core_done) begin
          cv_nxt = cv_new;
          if (fin_r) st_nxt = S_PAD;
          else if (pad_done_r) st_nxt = S_OUT;
          else st_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          oi_nxt = oi_r + 3'd1;
          if (oi_r == 3'd7) begin
            cv_nxt   = sm3_pkg::IV;
            bits_nxt = '0;
            st_nxt   = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // A message finishes when a compression ends after the length word was placed
  always_comb begin
    pad_done_nxt = pad_done_r;
    if (st_r == S_PAD && fill_r == 4'd15 && lhi_r) pad_done_nxt = 1'b1;
    if (st_r == S_OUT) pad_done_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      cv_r       <= sm3_pkg::IV;
      bits_r     <= '0;
      fill_r     <= '0;
      fin_r      <= 1'b0;
      xtra_r     <= 1'b0;
      lhi_r      <= 1'b0;
      oi_r       <= '0;
      pad_done_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      cv_r       <= cv_nxt;
      bits_r     <= bits_nxt;
      fill_r     <= fill_nxt;
      fin_r      <= fin_nxt;
      xtra_r     <= xtra_nxt;
      lhi_r      <= lhi_nxt;
      oi_r       <= oi_nxt;
      pad_done_r <= pad_done_nxt;
    end
  end

  assign out_valid       = (st_r == S_OUT);
  assign out_digest_word = cv_r[oi_r];
  assign out_word_index  = oi_r;
  assign out_digest_done = (oi_r == 3'd7);

`ifndef NO_ASSERTIONS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    core_busy |-> !in_ready) else $error("input taken during compression");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !core_busy) else $error("output while compressing");
  a_done_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_digest_done) |=> (bits_r == 64'd0 && fill_r == 4'd0))
    else $error("state not cleared after digest");
`endif

endmodule
`default_nettype wire

FILE: dv/sm3_hash_checker.sv
// Digest checker for sm3_hash: watches both channels, computes expected digest
// words with its own SM3 model and compares each output beat. Depends on sm3_pkg.
`default_nettype none
module sm3_hash_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] in_message_word,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic        in_is_last,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] out_digest_word,
  input  wire logic [2:0]  out_word_index,
  input  wire logic        out_digest_done,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        done;
  } digest_beat_t;

  digest_beat_t digest_q[$];
  logic [31:0] chain[8];
  logic [31:0] blk[16];
  logic [63:0] msg_bits;
  int          fill;

  assign pending = digest_q.size();

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  // One SM3 compression of blk into chain
  task automatic compress();
    logic [31:0] w[68];
    logic [31:0] r[8];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, x;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
      w[j] = (x ^ rol(x, 15) ^ rol(x, 23)) ^ rol(w[j-13], 7) ^ w[j-6];
    end
    for (int i = 0; i < 8; i++) r[i] = chain[i];
    for (int j = 0; j < 64; j++) begin
      tj = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
      a12 = rol(r[0], 12);
      ss1 = rol(a12 + r[4] + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + r[7] + ss1 + w[j];
      r[3] = r[2]; r[2] = rol(r[1], 9); r[1] = r[0]; r[0] = tt1;
      r[7] = r[6]; r[6] = rol(r[5], 19); r[5] = r[4];
      r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
    end
    for (int i = 0; i < 8; i++) chain[i] ^= r[i];
  endtask

  task automatic push(input logic [31:0] wd);
    blk[fill] = wd;
    fill++;
    if (fill == 16) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic absorb(input logic [31:0] wd, input logic [2:0] nb, input logic last);
    int n;
    logic [31:0] keep;
    n = (nb > 4) ? 4 : nb;
    if (!last) begin
      msg_bits += 64'd32;
      push(wd);
      return;
    end
    msg_bits += 64'(8 * n);
    if (n == 4) begin
      push(wd);
      push(32'h8000_0000);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (8 * (4 - n)));
      push((wd & keep) | (32'h80 << (8 * (3 - n))));
    end
    if (fill > 14) while (fill != 0) push(32'h0);
    while (fill < 14) push(32'h0);
    push(msg_bits[63:32]);
    push(msg_bits[31:0]);
    for (int i = 0; i < 8; i++) digest_q.push_back('{chain[i], 3'(i), i == 7});
    for (int i = 0; i < 8; i++) chain[i] = sm3_pkg::IV[i];
    msg_bits = '0;
    fill = 0;
  endtask

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    digest_beat_t exp_b;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) chain[i] = sm3_pkg::IV[i];
      msg_bits = '0;
      fill = 0;
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) absorb(in_message_word, in_valid_bytes, in_is_last);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected digest beat %h", out_digest_word);
        end else begin
          exp_b = digest_q.pop_front();
          if (exp_b != {out_digest_word, out_word_index, out_digest_done}) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b", exp_b.word,
                       exp_b.idx, exp_b.done, out_digest_word, out_word_index,
                       out_digest_done);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: dv/tb_sm3_hash.sv
// Testbench top for sm3_hash: drives message words under several idling
// phases and gives the verdict. Depends on sm3_hash, sm3_hash_checker.
`default_nettype none
module tb_sm3_hash;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [31:0] in_message_word = '0;
  logic [2:0]  in_valid_bytes = '0;
  logic        in_is_last = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_digest_done;
  int          fail_count, pending;
  int          send_idle = 0, recv_stall = 0;
  int          cycle = 0;

  always #4 clk = ~clk;

  sm3_hash u_dut (.*);
  sm3_hash_checker u_chk (.*);

  // Receiver stall
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    cycle++;
    if (cycle > 400000) begin
      $display("[sm3_hash] ERROR");
      $finish;
    end
  end

  // One beat; valid held until accepted
  task automatic send(input logic [31:0] wd, input logic [2:0] nb, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_message_word <= wd;
    in_valid_bytes <= nb;
    in_is_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Random message of len words, short ones mostly
  task automatic message(input int len);
    for (int i = 0; i < len - 1; i++)
      send($urandom, ($urandom_range(3) == 0) ? 3'($urandom) : 3'd4, 1'b0);
    send($urandom, 3'($urandom), 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    // Directed: empty message, odd counts, block boundaries, extremes
    send(32'h0, 3'd0, 1'b1);
    send(32'h6162_6300, 3'd3, 1'b1);
    send(32'hffff_ffff, 3'd7, 1'b1);
    send(32'hffff_ffff, 3'd1, 1'b1);
    send(32'h0, 3'd2, 1'b0);
    send(32'h1234_5678, 3'd5, 1'b1);
    for (int i = 0; i < 13; i++) send(32'h6162_6364, 3'd4, 1'b0);
    send(32'hffff_ffff, 3'd6, 1'b1);
    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 79 : 13) : 0;
      recv_stall = (ph == 2) ? 79 : ((ph == 3) ? 13 : 0);
      repeat (7) message(($urandom_range(7) == 0) ? $urandom_range(14, 34)
                                                  : $urandom_range(1, 4));
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[sm3_hash] OK");
    else
      $display("[sm3_hash] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
